>>> sv/keypad_number_entry_top_defines.svh
// Assertion macros for the keypad number entry block.
`ifndef KEYPAD_NUMBER_ENTRY_TOP_DEFINES_SVH
`define KEYPAD_NUMBER_ENTRY_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// a holds at an edge -> b holds at the same edge
`define KNE_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// a holds at an edge -> b holds at the next edge
`define KNE_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define KNE_ASSERT_IMPLY(label, clk, rst, a, b, msg)
`define KNE_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif

`endif

>>> sv/kne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kne_pkg;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] REG_BACKSPACE = 2'd1;
  localparam logic [1:0] REG_MAX_DIGITS = 2'd2;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
  localparam logic        BACKSPACE_RESET = 1'b1;
  localparam logic [3:0]  MAX_DIGITS_RESET = 4'd9;
  localparam logic [3:0]  DIGIT_LIMIT = 4'd9;

  // event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_DIGIT  = 2'd1;
  localparam logic [1:0] EV_REMOVE = 2'd2;
  localparam logic [1:0] EV_FINISH = 2'd3;

  // key codes
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;
  localparam logic [7:0] KEY_B    = 8'h42;
  localparam logic [7:0] KEY_D    = 8'h44;

  localparam logic [3:0] COLS_IDLE = 4'hF;

  // ceil(2^33 / 10): exact quotient for any value below 2^30
  localparam logic [29:0] RECIP10 = 30'd858993460;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic        backspace_enable;
    logic [3:0]  max_digits;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  row_drive;
    logic [1:0]  event_res;
    logic [7:0]  key_code;
    logic [3:0]  position;
    logic [29:0] value;
  } result_t;

  // 4x4 key map, row-major
  function automatic logic [7:0] key_lookup(logic [1:0] row, logic [1:0] col);
    logic [7:0] k;
    case ({row, col})
      4'd0:    k = 8'h31; // 1
      4'd1:    k = 8'h32; // 2
      4'd2:    k = 8'h33; // 3
      4'd3:    k = 8'h41; // A
      4'd4:    k = 8'h34; // 4
      4'd5:    k = 8'h35; // 5
      4'd6:    k = 8'h36; // 6
      4'd7:    k = 8'h42; // B
      4'd8:    k = 8'h37; // 7
      4'd9:    k = 8'h38; // 8
      4'd10:   k = 8'h39; // 9
      4'd11:   k = 8'h43; // C
      4'd12:   k = 8'h2A; // *
      4'd13:   k = 8'h30; // 0
      4'd14:   k = 8'h23; // #
      default: k = 8'h44; // D
    endcase
    return k;
  endfunction

  // row pattern grounding one row
  function automatic logic [3:0] row_ground(logic [1:0] r);
    logic [3:0] d;
    d = ~(4'b0001 << r);
    return d;
  endfunction

  // n / 10 by reciprocal multiply
  function automatic logic [29:0] div10(logic [29:0] n);
    logic [59:0] p;
    p = 60'(n) * 60'(RECIP10);
    return {3'b000, p[59:33]};
  endfunction

endpackage

`default_nettype wire

>>> sv/keypad_number_entry_top.sv
// Keypad number entry: scans a 4x4 matrix keypad and builds a decimal number.
// Input channel: one transfer per scan tick carries column_levels, the column
// pins sampled under the row_drive of the previous result (0 = pressed).
// Output channel: exactly one result transfer per input transfer, in order:
// row_drive for the next tick, event_res, key_code, position, value.
// Handshake: valid/stall on both sides; a transfer happens when valid is high
// and stall is low.
// Path: an input transfer is held in the input register, then the step logic
// writes its result into the result register.
// Throughput: one item per cycle unless the receiver stalls; the step is a single pass
// through the scan/debounce state machine and the times-ten or divide-by-ten datapath.
// Receiver stall: the result register holds; one more item is taken into the
// input register, after which in_stall rises until the result is taken.
// Reset (rst, synchronous, active high): scanner idle, entry cleared, no result
// valid, registers back to debounce 100, backspace on, 9 digits.
// Config: APB writes at 0x0 debounce_ticks, 0x4 backspace_enable,
// 0x8 max_digits; write only while no items are in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "keypad_number_entry_top_defines.svh"

module keypad_number_entry_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  column_levels,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       row_drive,
  output logic [1:0]       event_res,
  output logic [7:0]       key_code,
  output logic [3:0]       position,
  output logic [29:0]      value
);

  kne_pkg::cfg_t    cfg;
  kne_pkg::result_t res;

  // input register
  logic       s1_valid;
  logic [3:0] s1_cols;
  logic       take_in;
  logic       advance;

  // step the held item when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_in)      s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (advance)         out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (take_in) s1_cols <= column_levels;
  end

  kne_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kne_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .cols (s1_cols),
    .cfg  (cfg),
    .res  (res)
  );

  assign row_drive = res.row_drive;
  assign event_res = res.event_res;
  assign key_code  = res.key_code;
  assign position  = res.position;
  assign value     = res.value;

  // upstream only held off while an item sits in the input register
  `KNE_ASSERT_IMPLY(a_stall_held, clk, rst, in_stall, s1_valid && out_valid, "in_stall without a held item")
  // finishing an entry clears the digit count
  `KNE_ASSERT_IMPLY(a_finish_pos, clk, rst, out_valid && event_res == kne_pkg::EV_FINISH, position == 4'd0, "finish with nonzero position")
  // key actions happen with all rows grounded
  `KNE_ASSERT_IMPLY(a_event_rows, clk, rst, out_valid && event_res != kne_pkg::EV_NONE, row_drive == 4'h0, "event while scanning rows")
  // a stepped item shows up as a result on the next edge
  `KNE_ASSERT_NEXT(a_step_out, clk, rst, advance, out_valid, "stepped item lost")

endmodule

`default_nettype wire

>>> sv/kne_apb.sv
`timescale 1ns / 1ps
`default_nettype none

module kne_apb (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output kne_pkg::cfg_t     cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= kne_pkg::DEBOUNCE_RESET;
      cfg.backspace_enable <= kne_pkg::BACKSPACE_RESET;
      cfg.max_digits       <= kne_pkg::MAX_DIGITS_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        kne_pkg::REG_DEBOUNCE:   cfg.debounce_ticks   <= pwdata[15:0];
        kne_pkg::REG_BACKSPACE:  cfg.backspace_enable <= pwdata[0];
        kne_pkg::REG_MAX_DIGITS: cfg.max_digits       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kne_pkg::REG_DEBOUNCE:   prdata = {16'h0000, cfg.debounce_ticks};
      kne_pkg::REG_BACKSPACE:  prdata = {31'h0, cfg.backspace_enable};
      kne_pkg::REG_MAX_DIGITS: prdata = {28'h0, cfg.max_digits};
      default:                 prdata = 32'h0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/kne_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

module kne_fsm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire logic [3:0]      cols,
  input  wire kne_pkg::cfg_t   cfg,
  output kne_pkg::result_t     res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SCAN,
    PH_COLS,
    PH_WAIT,
    PH_RELEASE
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  scan_row, scan_row_next;
  logic [1:0]  found_row, found_row_next;
  logic [7:0]  pending_key, pending_key_next;
  logic [15:0] wait_count, wait_count_next;
  logic [29:0] entry_value, entry_value_next;
  logic [3:0]  digit_count, digit_count_next;

  kne_pkg::result_t res_next;

  logic [3:0]  limit;
  logic [1:0]  first_col;
  logic        col_found;
  logic [3:0]  digit;
  logic [29:0] times10;

  assign limit   = (cfg.max_digits > kne_pkg::DIGIT_LIMIT) ? kne_pkg::DIGIT_LIMIT
                                                           : cfg.max_digits;
  // ASCII '0'..'9': the low nibble is the digit
  assign digit   = pending_key[3:0];
  assign times10 = {entry_value[26:0], 3'b000} + {entry_value[28:0], 1'b0};

  // lowest low column
  always_comb begin
    col_found = 1'b1;
    first_col = 2'd0;
    if (!cols[0])      first_col = 2'd0;
    else if (!cols[1]) first_col = 2'd1;
    else if (!cols[2]) first_col = 2'd2;
    else if (!cols[3]) first_col = 2'd3;
    else               col_found = 1'b0;
  end

  always_comb begin
    phase_next       = phase;
    scan_row_next    = scan_row;
    found_row_next   = found_row;
    pending_key_next = pending_key;
    wait_count_next  = wait_count;
    entry_value_next = entry_value;
    digit_count_next = digit_count;
    res_next.row_drive = 4'h0;
    res_next.event_res = kne_pkg::EV_NONE;
    res_next.key_code  = 8'h00;

    case (phase)
      PH_SCAN: begin
        if (cols != kne_pkg::COLS_IDLE) begin
          found_row_next = scan_row;
          phase_next     = PH_COLS;
        end else if (scan_row == 2'd3) begin
          phase_next = PH_IDLE;
        end else begin
          scan_row_next      = scan_row + 2'd1;
          res_next.row_drive = kne_pkg::row_ground(scan_row + 2'd1);
        end
      end
      PH_COLS: begin
        if (col_found) begin
          pending_key_next = kne_pkg::key_lookup(found_row, first_col);
          wait_count_next  = cfg.debounce_ticks;
          phase_next       = PH_WAIT;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (wait_count != 16'd0) begin
          wait_count_next = wait_count - 16'd1;
        end else begin
          if (pending_key inside {[kne_pkg::KEY_ZERO:kne_pkg::KEY_NINE]}) begin
            if (digit_count < limit) begin
              entry_value_next   = times10 + {26'h0, digit};
              digit_count_next   = digit_count + 4'd1;
              res_next.event_res = kne_pkg::EV_DIGIT;
              res_next.key_code  = pending_key;
            end
          end else if (pending_key == kne_pkg::KEY_B) begin
            if (cfg.backspace_enable && digit_count != 4'd0) begin
              entry_value_next   = kne_pkg::div10(entry_value);
              digit_count_next   = digit_count - 4'd1;
              res_next.event_res = kne_pkg::EV_REMOVE;
              res_next.key_code  = pending_key;
            end
          end else if (pending_key == kne_pkg::KEY_D) begin
            entry_value_next   = 30'd0;
            digit_count_next   = 4'd0;
            res_next.event_res = kne_pkg::EV_FINISH;
            res_next.key_code  = pending_key;
          end
          phase_next = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (cols == kne_pkg::COLS_IDLE) phase_next = PH_IDLE;
      end
      default: begin
        // idle, and any stray code
        phase_next = PH_IDLE;
        if (cols != kne_pkg::COLS_IDLE) begin
          phase_next         = PH_SCAN;
          scan_row_next      = 2'd0;
          res_next.row_drive = kne_pkg::row_ground(2'd0);
        end
      end
    endcase

    res_next.position = digit_count_next;
    // finished entry reports the number before clearing
    res_next.value = (res_next.event_res == kne_pkg::EV_FINISH) ? entry_value
                                                                : entry_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      scan_row    <= 2'd0;
      found_row   <= 2'd0;
      pending_key <= 8'h00;
      wait_count  <= 16'd0;
      entry_value <= 30'd0;
      digit_count <= 4'd0;
    end else if (go) begin
      phase       <= phase_next;
      scan_row    <= scan_row_next;
      found_row   <= found_row_next;
      pending_key <= pending_key_next;
      wait_count  <= wait_count_next;
      entry_value <= entry_value_next;
      digit_count <= digit_count_next;
    end
    if (go) res <= res_next;
  end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

// Keypad number entry testbench.
// The sender plays a 4x4 keypad: each transfer carries the column levels seen
// under the row drive that the block's previous result asked for, so presses
// run through the whole scan, debounce and release sequence. A scan-tick model
// of the block predicts every result at input acceptance; the checker
// compares each output transfer field by field against the oldest prediction.
module tb;
  import kne_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000; // cycles before the run is abandoned
  localparam int HOLD_CYCLES  = 150;       // long receiver hold-off
  localparam int RANDOM_TICKS = 100;

  // key positions, index = row * 4 + column
  localparam logic [3:0] KEY_A_AT    = 4'd3;
  localparam logic [3:0] KEY_B_AT    = 4'd7;
  localparam logic [3:0] KEY_C_AT    = 4'd11;
  localparam logic [3:0] KEY_STAR_AT = 4'd12;
  localparam logic [3:0] KEY_HASH_AT = 4'd14;
  localparam logic [3:0] KEY_D_AT    = 4'd15;

  localparam logic [7:0] KEY_A    = 8'h41;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_HASH = 8'h23;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SCAN, PH_COLS, PH_DEBOUNCE, PH_RELEASE
  } keypad_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  column_levels = 4'hF;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  row_drive;
  logic [1:0]  event_res;
  logic [7:0]  key_code;
  logic [3:0]  position;
  logic [29:0] value;

  keypad_number_entry_top u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .column_levels (column_levels),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_drive     (row_drive),
    .event_res     (event_res),
    .key_code      (key_code),
    .position      (position),
    .value         (value)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Scan-tick model: its own copy of the registers and scanner state
  // ---------------------------------------------------------------------
  cfg_t          setting;
  keypad_phase_t scan_phase;
  logic [1:0]    probe_row;
  logic [1:0]    hit_row;
  logic [7:0]    held_key;
  logic [15:0]   countdown;
  logic [29:0]   number;
  logic [3:0]    digits;
  logic [3:0]    last_drive;   // row drive of the latest predicted result

  result_t scan_results_due[$];
  int      mismatches = 0;
  int      ticks_sent = 0;
  int      cycles = 0;
  bit      steady = 1'b0;      // no sender gaps or random receiver stalls while set
  logic    holding = 1'b0;     // receiver held off
  event    hold_off_go;

  // legend of the key at a matrix position
  function automatic logic [7:0] legend(logic [3:0] idx);
    logic [1:0] r;
    logic [1:0] c;
    r = idx[3:2];
    c = idx[1:0];
    if (c == 2'd3) return 8'(KEY_A + r);  // A B C D down the last column
    if (r == 2'd3) return (c == 2'd0) ? KEY_STAR : (c == 2'd1) ? KEY_ZERO : KEY_HASH;
    return 8'(KEY_ZERO + 1 + 3 * r + c);
  endfunction

  // one scan tick; updates the model state, returns the result transfer
  function automatic result_t keypad_step(logic [3:0] cols);
    result_t     res;
    logic [3:0]  lim;
    logic [29:0] report;
    bit          finished;
    int          c;
    res = '0;
    report = '0;
    finished = 1'b0;
    lim = (setting.max_digits > DIGIT_LIMIT) ? DIGIT_LIMIT : setting.max_digits;
    case (scan_phase)
      PH_SCAN: begin
        if (cols != COLS_IDLE) begin
          hit_row = probe_row;
          scan_phase = PH_COLS;
        end else if (probe_row == 2'd3) begin
          scan_phase = PH_IDLE;           // no row shows a low column
        end else begin
          probe_row = probe_row + 2'd1;
          res.row_drive = 4'hF ^ (4'h1 << probe_row);
        end
      end
      PH_COLS: begin
        c = 0;
        while (c < 4 && cols[c]) c++;
        if (c < 4) begin
          held_key = legend({hit_row, 2'(c)});
          countdown = setting.debounce_ticks;
          scan_phase = PH_DEBOUNCE;
        end else begin
          scan_phase = PH_IDLE;           // key gone before the column read
        end
      end
      PH_DEBOUNCE: begin
        if (countdown != 0) begin
          countdown = countdown - 16'd1;
        end else begin
          if (held_key >= KEY_ZERO && held_key <= KEY_NINE) begin
            if (digits < lim) begin
              number = number * 30'd10 + 30'(held_key - KEY_ZERO);
              digits = digits + 4'd1;
              res.event_res = EV_DIGIT;
              res.key_code = held_key;
            end
          end else if (held_key == KEY_B) begin
            if (setting.backspace_enable && digits != 0) begin
              digits = digits - 4'd1;
              number = number / 30'd10;
              res.event_res = EV_REMOVE;
              res.key_code = held_key;
            end
          end else if (held_key == KEY_D) begin
            res.event_res = EV_FINISH;
            res.key_code = held_key;
            report = number;
            finished = 1'b1;
            number = '0;
            digits = '0;
          end
          scan_phase = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (cols == COLS_IDLE) scan_phase = PH_IDLE;
      end
      default: begin
        if (cols != COLS_IDLE) begin
          scan_phase = PH_SCAN;
          probe_row = 2'd0;
          res.row_drive = 4'hE;
        end
      end
    endcase
    res.position = digits;
    res.value = finished ? report : number;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one input transfer; predicted at the edge it is taken
  task automatic tick(input logic [3:0] cols);
    int      gap;
    result_t res;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    column_levels <= cols;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = keypad_step(cols);
    scan_results_due.push_back(res);
    last_drive = res.row_drive;
    ticks_sent++;
  endtask

  // columns seen with the given keys held, under the current row drive
  task automatic tick_keys(input logic [15:0] held, input bit bouncy);
    logic [3:0] cols;
    int         r;
    cols = COLS_IDLE;
    for (r = 0; r < 4; r++)
      if (!last_drive[r]) cols &= ~held[r*4 +: 4];
    if (bouncy && $urandom_range(0, 7) == 0) cols ^= 4'($urandom);
    tick(cols);
  endtask

  // all keys up until the scanner is back in idle
  task automatic settle();
    while (scan_phase != PH_IDLE) tick(COLS_IDLE);
  endtask

  // hold keys until acted on, linger, then release
  task automatic press_keys(input logic [15:0] held, input bit bouncy);
    int guard;
    guard = 0;
    while (scan_phase != PH_RELEASE && guard < int'(setting.debounce_ticks) + 40) begin
      tick_keys(held, bouncy);
      guard++;
    end
    repeat ($urandom_range(0, 3)) tick_keys(held, bouncy);
    repeat ($urandom_range(1, 3)) tick_keys(16'h0, bouncy);
    settle();
  endtask

  function automatic logic [3:0] digit_key_at(int d);
    if (d == 0) return 4'd13;
    return 4'(((d - 1) / 3) * 4 + (d - 1) % 3);
  endfunction

  function automatic logic [3:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58) return digit_key_at($urandom_range(0, 9));
    if (r < 73) return KEY_B_AT;
    if (r < 85) return KEY_D_AT;
    case ($urandom_range(0, 3))
      0:       return KEY_A_AT;
      1:       return KEY_C_AT;
      2:       return KEY_STAR_AT;
      default: return KEY_HASH_AT;
    endcase
  endfunction

  task automatic press(input logic [3:0] idx);
    press_keys(16'h1 << idx, 1'b0);
  endtask

  task automatic press_digits(input int n);
    repeat (n) press(digit_key_at($urandom_range(0, 9)));
  endtask

  // lower valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write with junk in the unused upper bits, then read back
  task automatic set_register(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] data;
    logic [31:0] want;
    logic [31:0] got;
    data = $urandom;
    case (idx)
      REG_DEBOUNCE: begin
        data[15:0] = val;
        want = {16'h0, val};
        setting.debounce_ticks = val;
      end
      REG_BACKSPACE: begin
        data[0] = val[0];
        want = {31'h0, val[0]};
        setting.backspace_enable = val[0];
      end
      default: begin
        data[3:0] = val[3:0];
        want = {28'h0, val[3:0]};
        setting.max_digits = val[3:0];
      end
    endcase
    apb_access(idx, 1'b1, data, got);
    apb_access(idx, 1'b0, 32'h0, got);
    if (got !== want) begin
      $display("%0t: register %0d readback expected %0h actual %0h", $time, idx, want, got);
      mismatches++;
    end
  endtask

  task automatic configure(input logic [15:0] deb, input logic bs, input logic [3:0] maxd);
    wait_drained();
    set_register(REG_DEBOUNCE, deb);
    set_register(REG_BACKSPACE, {15'h0, bs});
    set_register(REG_MAX_DIGITS, {12'h0, maxd});
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------
  initial forever begin
    @(hold_off_go);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  int stall_run = 0;
  int free_run = 0;

  always @(posedge clk) begin : drive_stall
    int r;
    if (holding) begin
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (free_run != 0) begin
      out_stall <= 1'b0;
      free_run--;
    end else begin
      r = $urandom_range(0, 99);
      stall_run = (r < 80) ? $urandom_range(1, 3) :
                  (r < 95) ? $urandom_range(4, 10) : $urandom_range(20, 50);
      free_run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                              : $urandom_range(40, 150);
      out_stall <= 1'b0;
    end
  end

  task automatic flag_field(input string name, input logic [29:0] want, input logic [29:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    mismatches++;
  endtask

  // every result transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (scan_results_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h/%0d/%h/%0d/%0d",
                 $time, row_drive, event_res, key_code, position, value);
        mismatches++;
      end else begin
        want = scan_results_due.pop_front();
        if (row_drive !== want.row_drive) flag_field("row_drive", want.row_drive, row_drive);
        if (event_res !== want.event_res) flag_field("event_res", want.event_res, event_res);
        if (key_code !== want.key_code) flag_field("key_code", want.key_code, key_code);
        if (position !== want.position) flag_field("position", want.position, position);
        if (value !== want.value) flag_field("value", want.value, value);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // reset values: a 100-tick debounce, then the number reported
  task automatic test_reset_defaults();
    press(digit_key_at(7));
    press(KEY_D_AT);
  endtask

  // raw column words: idle, a scan with no row, a row with no column,
  // several columns low at once, and the bottom-right key
  task automatic test_edge_scans();
    configure(16'd0, 1'b1, 4'd9);
    tick(COLS_IDLE);
    tick(4'hE);
    repeat (4) tick(COLS_IDLE);
    tick(4'h7);
    tick(4'h0);
    tick(COLS_IDLE);
    repeat (5) tick(4'h0);     // first low column wins, key 1 accepted
    tick(COLS_IDLE);
    press(digit_key_at(0));
    press(KEY_D_AT);
  endtask

  task automatic test_digit_limit();
    configure(16'd0, 1'b1, 4'd1);
    press_digits(3);
    press(KEY_D_AT);
    configure(16'd2, 1'b1, 4'd0);  // no digit accepted at all
    press_digits(2);
    press(KEY_D_AT);
    configure(16'd0, 1'b0, 4'd15); // above nine acts as nine
    press_digits(11);
    press(KEY_D_AT);
    configure(16'd1, 1'b1, 4'd10);
    repeat (10) press(digit_key_at(9)); // largest number the entry can hold
    press(KEY_D_AT);
  endtask

  task automatic test_backspace();
    configure(16'd0, 1'b1, 4'd9);
    press(KEY_B_AT);               // empty entry: nothing to remove
    press_digits(3);
    repeat (4) press(KEY_B_AT);
    press_digits(2);
    press(KEY_D_AT);
    configure(16'd3, 1'b0, 4'd9);
    press_digits(2);
    press(KEY_B_AT);               // switched off
    press(KEY_D_AT);
  endtask

  // letters and symbols give no event, but still wait for release
  task automatic test_other_keys();
    configure(16'd1, 1'b1, 4'd9);
    press(KEY_A_AT);
    press(KEY_C_AT);
    press(KEY_STAR_AT);
    press(KEY_HASH_AT);
    press_digits(2);
    press_keys((16'h1 << KEY_HASH_AT) | (16'h1 << digit_key_at(4)), 1'b0);
    press_keys((16'h1 << KEY_D_AT) | (16'h1 << KEY_A_AT), 1'b1);
    press_keys(16'hFFFF, 1'b0);
    press(KEY_D_AT);
  endtask

  // receiver holds off while the sender keeps offering, then the sender
  // pauses until the block has emptied
  task automatic test_backpressure();
    configure(16'd0, 1'b1, 4'd9);
    steady = 1'b1;
    -> hold_off_go;
    press_digits(6);
    wait_drained();
    press_digits(2);
    press(KEY_D_AT);
    steady = 1'b0;
  endtask

  task automatic test_random_entry();
    int          first;
    int          r;
    logic [15:0] deb;
    logic [3:0]  maxd;
    logic [15:0] held;
    first = ticks_sent;
    while (ticks_sent - first < RANDOM_TICKS) begin
      r = $urandom_range(0, 99);
      deb = (r < 70) ? 16'($urandom_range(0, 3)) :
            (r < 95) ? 16'($urandom_range(4, 15)) : 16'($urandom_range(50, 120));
      if ($urandom_range(0, 9) < 8) maxd = 4'($urandom_range(1, 9));
      else maxd = ($urandom_range(0, 2) == 0) ? 4'd0 : ($urandom_range(0, 1) ? 4'd10 : 4'd15);
      configure(deb, 1'($urandom_range(0, 1)), maxd);
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(15, 40)) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          press_keys(16'h1 << pick_key(), $urandom_range(0, 3) == 0);
        end else if (r < 78) begin
          press_keys((16'h1 << pick_key()) | (16'h1 << pick_key()), 1'b0);
        end else if (r < 90) begin
          // let go part way through the scan
          held = 16'h1 << pick_key();
          repeat ($urandom_range(1, 4)) tick_keys(held, 1'b0);
          settle();
        end else begin
          repeat ($urandom_range(1, 6)) tick(4'($urandom));
          settle();
        end
      end
      steady = 1'b0;
    end
  endtask

  // long debounce with the upper count byte in use, then a quick finish
  task automatic test_long_debounce();
    configure(16'h0101, 1'b1, 4'd9);
    steady = 1'b1;
    press(digit_key_at(3));
    steady = 1'b0;
    configure(16'd0, 1'b1, 4'd9);
    press(KEY_D_AT);
  endtask

  initial begin
    setting.debounce_ticks = DEBOUNCE_RESET;
    setting.backspace_enable = BACKSPACE_RESET;
    setting.max_digits = MAX_DIGITS_RESET;
    scan_phase = PH_IDLE;
    probe_row = '0;
    hit_row = '0;
    held_key = '0;
    countdown = '0;
    number = '0;
    digits = '0;
    last_drive = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_edge_scans();
    test_digit_limit();
    test_backspace();
    test_other_keys();
    test_backpressure();
    test_random_entry();
    test_long_debounce();

    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
